>>> src/assert_macros.svh
// Assertion helpers. Each expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    // request codes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_POP_BACK   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_READ_INDEX = 3'd4;
    localparam logic [2:0] OP_RESIZE     = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;
    localparam logic [2:0] OP_QUERY      = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OOB   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // fixed width of the position field
    localparam int POS_W   = 7;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_r;   // everyone takes the left neighbor (push front)
        logic shift_l;   // everyone takes the right neighbor (pop front)
        logic fill;      // cells inside [lo, hi) take the fill word
        logic rd_load;   // read line copies the cell contents
        logic rd_shift;  // read line moves one place toward cell 0
    } cell_ctl_t;

endpackage

>>> src/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// request   in_valid / in_ready   operation, value, position
// result    out_valid / out_ready status, front_value, back_value, read_value,
//                                 count, is_empty
//
// Most requests need no walk: the row of cells shifts or fills in place.
// A read_index that succeeds, pop back with two or more held and a resize down to a
// nonzero length walk the read line instead: it copies the cells, then moves one cell
// per cycle toward cell 0 until the element wanted (index up to DEPTH-1) reaches it.
// One request at a time; a new beat is taken when idle and the result slot is free
// or being drained. rst_n is asynchronous; cell contents are not cleared.
// A stalled result holds the block in its finishing step.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [6:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic signed [31:0] read_value,
    output logic [6:0]         count,
    output logic               is_empty
);

    localparam int CW = $clog2(DEPTH + 1);                 // element count width
    localparam int IW = $clog2(DEPTH);                     // index width
    localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W; // compare width

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Cell i always holds element i: front is cell 0, no head pointer needed.
    logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_line   [DEPTH];
    logic signed [DATA_WIDTH-1:0] val_st;

    deq_pkg::cell_ctl_t ctl;
    logic [CW-1:0]      lo;
    logic [CW-1:0]      hi;

    logic               state_reg;
    logic [CW-1:0]      fill_cnt_reg;
    logic [CW-1:0]      fill_cnt_next;
    logic signed [DATA_WIDTH-1:0] back_reg;
    logic signed [DATA_WIDTH-1:0] back_next;
    logic signed [DATA_WIDTH-1:0] front_new;
    logic [IW-1:0]      rem_reg;
    logic [IW-1:0]      rem_next;
    logic               kind_back_reg;   // 1: pending read refreshes back, 0: read_index
    logic               kind_back_next;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] front_reg;
    logic signed [31:0] back_out_reg;
    logic signed [31:0] read_reg;
    logic [6:0]         count_reg;
    logic               is_empty_reg;

    logic               in_fire;
    logic               out_free;
    logic               multi;
    logic               finish;
    logic [1:0]         st_new;
    logic               is_full;
    logic               is_emp;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_ext;

    assign val_st   = DATA_WIDTH'(value);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign finish   = (state_reg == ST_RUN) && (rem_reg == '0) && out_free;
    assign is_full  = (fill_cnt_reg == CW'(DEPTH));
    assign is_emp   = (fill_cnt_reg == '0);
    assign pos_ext  = PW'(position);
    assign cnt_ext  = PW'(fill_cnt_reg);

    // Request decode: cell command plus next count/back/front.
    always_comb
    begin
        ctl            = '0;
        lo             = fill_cnt_reg;
        hi             = fill_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        back_next      = back_reg;
        front_new      = cell_data[0];
        st_new         = deq_pkg::ST_OK;
        multi          = 1'b0;
        kind_back_next = kind_back_reg;
        rem_next       = rem_reg;

        if (in_fire)
        begin
            unique case (operation)
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        st_new = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.fill      = 1'b1;
                        hi            = fill_cnt_reg + CW'(1);
                        fill_cnt_next = fill_cnt_reg + CW'(1);
                        back_next     = val_st;
                        if (is_emp)
                        begin
                            front_new = val_st;
                        end
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (is_emp)
                    begin
                        st_new = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fill_cnt_next = fill_cnt_reg - CW'(1);
                        // new back is element count-2; fetch it over the read line
                        if (fill_cnt_reg != CW'(1))
                        begin
                            multi          = 1'b1;
                            kind_back_next = 1'b1;
                            rem_next       = IW'(fill_cnt_reg - CW'(2));
                        end
                    end
                end
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        st_new = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.shift_r   = 1'b1;
                        fill_cnt_next = fill_cnt_reg + CW'(1);
                        front_new     = val_st;
                        if (is_emp)
                        begin
                            back_next = val_st;
                        end
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (is_emp)
                    begin
                        st_new = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.shift_l   = 1'b1;
                        fill_cnt_next = fill_cnt_reg - CW'(1);
                        front_new     = cell_data[1];
                    end
                end
                deq_pkg::OP_READ_INDEX:
                begin
                    if (is_emp)
                    begin
                        st_new = deq_pkg::ST_EMPTY;
                    end
                    else if (pos_ext >= cnt_ext)
                    begin
                        st_new = deq_pkg::ST_OOB;
                    end
                    else
                    begin
                        multi          = 1'b1;
                        kind_back_next = 1'b0;
                        rem_next       = IW'(position);
                    end
                end
                deq_pkg::OP_RESIZE:
                begin
                    if (pos_ext > PW'(DEPTH))
                    begin
                        st_new = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        fill_cnt_next = CW'(position);
                        if (pos_ext > cnt_ext)
                        begin
                            // grow: every new slot gets the fill word at once
                            ctl.fill  = 1'b1;
                            hi        = CW'(position);
                            back_next = val_st;
                            if (is_emp)
                            begin
                                front_new = val_st;
                            end
                        end
                        else if ((pos_ext < cnt_ext) && (position != '0))
                        begin
                            multi          = 1'b1;
                            kind_back_next = 1'b1;
                            rem_next       = IW'(position - 7'd1);
                        end
                        else
                        begin
                            // same length, or shrink to nothing
                        end
                    end
                end
                deq_pkg::OP_CLEAR:
                begin
                    fill_cnt_next = '0;
                end
                deq_pkg::OP_QUERY:
                begin
                end
            endcase
            ctl.rd_load = multi;
        end
        else if ((state_reg == ST_RUN) && (rem_reg != '0))
        begin
            ctl.rd_shift = 1'b1;
            rem_next     = rem_reg - IW'(1);
        end
        else
        begin
        end
    end

    // The row of cells and the read line beside it.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_d;
        logic signed [DATA_WIDTH-1:0] right_d;
        logic signed [DATA_WIDTH-1:0] rd_r;

        if (i == 0)
        begin : g_first
            assign left_d = val_st;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
            assign rd_r    = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
            assign rd_r    = rd_line[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .lo         (lo),
            .hi         (hi),
            .fill_data  (val_st),
            .left_data  (left_d),
            .right_data (right_d),
            .rd_right   (rd_r),
            .data       (cell_data[i]),
            .rd         (rd_line[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_cnt_reg  <= '0;
            rem_reg       <= '0;
            kind_back_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_cnt_reg  <= fill_cnt_next;
            rem_reg       <= rem_next;
            kind_back_reg <= kind_back_next;
            if (in_fire && multi)
            begin
                state_reg <= ST_RUN;
            end
            else if (finish)
            begin
                state_reg <= ST_IDLE;
            end
            else
            begin
                state_reg <= state_reg;
            end

            if ((in_fire && !multi) || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    // back tracking and result beat
    always_ff @(posedge clk)
    begin
        if (finish && kind_back_reg)
        begin
            back_reg <= rd_line[0];
        end
        else
        begin
            back_reg <= back_next;
        end

        if (in_fire && !multi)
        begin
            status_reg   <= st_new;
            front_reg    <= (fill_cnt_next == '0) ? '0 : 32'(front_new);
            back_out_reg <= (fill_cnt_next == '0) ? '0 : 32'(back_next);
            read_reg     <= '0;
            count_reg    <= 7'(fill_cnt_next);
            is_empty_reg <= (fill_cnt_next == '0);
        end
        else if (finish)
        begin
            // every multi-cycle request leaves at least one element
            status_reg   <= deq_pkg::ST_OK;
            front_reg    <= 32'(cell_data[0]);
            back_out_reg <= kind_back_reg ? 32'(rd_line[0]) : 32'(back_reg);
            read_reg     <= kind_back_reg ? '0 : 32'(rd_line[0]);
            count_reg    <= 7'(fill_cnt_reg);
            is_empty_reg <= 1'b0;
        end
        else
        begin
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign front_value = front_reg;
    assign back_value  = back_out_reg;
    assign read_value  = read_reg;
    assign count       = count_reg;
    assign is_empty    = is_empty_reg;

    `ASSERT_ALWAYS(a_cnt_bound, fill_cnt_reg <= CW'(DEPTH), "element count above DEPTH")
    `ASSERT_NEXT(a_push_grows, in_fire && (operation == deq_pkg::OP_PUSH_BACK) && !is_full, fill_cnt_reg == $past(fill_cnt_reg) + CW'(1), "push back did not grow count")
    `ASSERT_IMPL(a_idle_rem, state_reg == ST_IDLE, rem_reg == '0, "read line countdown left over while idle")
    `ASSERT_NEXT(a_run_done, finish, (state_reg == ST_IDLE) && out_valid_reg, "finished read did not post a result")
    `ASSERT_IMPL(a_empty_flag, out_valid_reg, is_empty_reg == (count_reg == '0), "empty flag disagrees with count")

endmodule

>>> src/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 7,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  deq_pkg::cell_ctl_t           ctl,
    input  logic [CW-1:0]                lo,
    input  logic [CW-1:0]                hi,
    input  logic signed [DATA_WIDTH-1:0] fill_data,
    input  logic signed [DATA_WIDTH-1:0] left_data,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    input  logic signed [DATA_WIDTH-1:0] rd_right,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic signed [DATA_WIDTH-1:0] rd
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] rd_reg;
    logic                         in_rng;

    assign in_rng = (MY_IDX >= lo) && (MY_IDX < hi);

    always_ff @(posedge clk)
    begin
        priority if (ctl.shift_r)
        begin
            data_reg <= left_data;
        end
        else if (ctl.shift_l)
        begin
            data_reg <= right_data;
        end
        else if (ctl.fill && in_rng)
        begin
            data_reg <= fill_data;
        end
        else
        begin
            data_reg <= data_reg;
        end

        priority if (ctl.rd_load)
        begin
            rd_reg <= data_reg;
        end
        else if (ctl.rd_shift)
        begin
            rd_reg <= rd_right;
        end
        else
        begin
            rd_reg <= rd_reg;
        end
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

>>> tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import deq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int RAND_PHASE  = 125;      // random beats per idling phase

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // one result beat, field for field
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front;
        logic signed [31:0] back;
        logic signed [31:0] rd;
        logic [6:0]         cnt;
        logic               empty;
    } deq_result_t;

    // one row of the directed table
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] val;
        logic [6:0]         pos;
        bit                 typed;   // hand-written expectation in res
        deq_result_t        res;
    } deq_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         operation = OP_QUERY;
    logic signed [31:0] value = '0;
    logic [6:0]         position = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               is_empty;

    // mirror of the deque contents
    logic signed [31:0] ring_mem [DEPTH];
    int                 ring_head = 0;
    int                 held = 0;

    deq_result_t        pending_results[$];
    deq_row_t           directed_rows[$];

    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 idle_pct = 0;     // sender gap chance per cycle
    int                 stall_pct = 0;    // receiver stall chance per cycle

    double_ended_queue uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .front_value(front_value),
        .back_value (back_value),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ring slot of the element at a given offset from the front
    function automatic int ring_slot(int off);
        return (ring_head + off) % DEPTH;
    endfunction

    // Applies one request to the mirror and returns the result beat it yields.
    function automatic deq_result_t deque_apply(logic [2:0] op, logic signed [31:0] val,
                                                logic [6:0] pos);
        deq_result_t r;
        int          i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK:
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    ring_mem[ring_slot(held)] = val;
                    held++;
                end
            OP_POP_BACK:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                    held--;
            OP_PUSH_FRONT:
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
                    ring_mem[ring_head] = val;
                    held++;
                end
            OP_POP_FRONT:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    ring_head = (ring_head + 1) % DEPTH;
                    held--;
                end
            OP_READ_INDEX:
                if (held == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) >= held)
                    r.status = ST_OOB;
                else
                    r.rd = ring_mem[ring_slot(int'(pos))];
            OP_RESIZE:
                if (int'(pos) > DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // growing appends copies of the fill word, shrinking drops from the back
                    for (i = held; i < int'(pos); i++)
                        ring_mem[ring_slot(i)] = val;
                    held = int'(pos);
                end
            OP_CLEAR:
            begin
                held = 0;
                ring_head = 0;
            end
            default: ;   // query leaves everything as is
        endcase
        if (held != 0)
        begin
            r.front = ring_mem[ring_slot(0)];
            r.back  = ring_mem[ring_slot(held - 1)];
        end
        r.cnt   = held[6:0];
        r.empty = (held == 0);
        return r;
    endfunction

    task automatic add_row(logic [2:0] op, logic signed [31:0] val, logic [6:0] pos,
                           bit typed, logic [1:0] st, logic signed [31:0] fr,
                           logic signed [31:0] bk, logic signed [31:0] rd, logic [6:0] cnt);
        deq_row_t row;
        row.op    = op;
        row.val   = val;
        row.pos   = pos;
        row.typed = typed;
        row.res   = '{status: st, front: fr, back: bk, rd: rd, cnt: cnt, empty: (cnt == 0)};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Drives one request beat, waits for the handshake, then records what it must return.
    // in_valid is assigned once per time step: either dropped for a gap or raised for the beat.
    task automatic send_request(logic [2:0] op, logic signed [31:0] val, logic [6:0] pos,
                                bit typed, deq_result_t typed_res);
        deq_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        position  <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge; the mirror always advances
        r = deque_apply(op, val, pos);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    // Result side: check each beat against the oldest expectation, then pick the next
    // stall. out_ready and the result fields are read before this edge's updates land.
    always @(posedge clk)
    begin
        deq_result_t got;
        deq_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status: status, front: front_value, back: back_value,
                    rd: read_value, cnt: count, empty: is_empty};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat with nothing expected: st=%0d cnt=%0d",
                             got.status, got.cnt);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.status !== want.status || got.front !== want.front ||
                    got.back !== want.back || got.rd !== want.rd ||
                    got.cnt !== want.cnt || got.empty !== want.empty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch at %0t: expected st=%0d front=%0d back=%0d rd=%0d cnt=%0d empty=%0d",
                                 $realtime, want.status, want.front, want.back, want.rd,
                                 want.cnt, want.empty);
                        $display("    got st=%0d front=%0d back=%0d rd=%0d cnt=%0d empty=%0d",
                                 got.status, got.front, got.back, got.rd, got.cnt,
                                 got.empty);
                    end
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("double_ended_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int          sel;
        int          fill_bias;
        int          lo;
        int          hi;
        logic [2:0]  op;
        logic signed [31:0] val;
        logic [6:0]  pos;
        deq_row_t    row;

        // Directed table. Typed rows cover the reset state, the extremes and every
        // error code; the rest (wrap of the head, shrink, pops) go through the mirror.
        add_row(OP_QUERY,      0,       0,   1, ST_OK,    0,       0,       0,       0);
        add_row(OP_POP_BACK,   0,       0,   1, ST_EMPTY, 0,       0,       0,       0);
        add_row(OP_POP_FRONT,  0,       0,   1, ST_EMPTY, 0,       0,       0,       0);
        add_row(OP_READ_INDEX, 0,       0,   1, ST_EMPTY, 0,       0,       0,       0);
        add_row(OP_PUSH_BACK,  VAL_MAX, 0,   1, ST_OK,    VAL_MAX, VAL_MAX, 0,       1);
        add_row(OP_PUSH_FRONT, VAL_MIN, 0,   1, ST_OK,    VAL_MIN, VAL_MAX, 0,       2);
        add_row(OP_READ_INDEX, 0,       0,   1, ST_OK,    VAL_MIN, VAL_MAX, VAL_MIN, 2);
        add_row(OP_READ_INDEX, 0,       1,   1, ST_OK,    VAL_MIN, VAL_MAX, VAL_MAX, 2);
        add_row(OP_READ_INDEX, 0,       2,   1, ST_OOB,   VAL_MIN, VAL_MAX, 0,       2);
        add_row(OP_READ_INDEX, 0,       127, 1, ST_OOB,   VAL_MIN, VAL_MAX, 0,       2);
        // resize to the current length is a no-op
        add_row(OP_RESIZE,     99,      2,   1, ST_OK,    VAL_MIN, VAL_MAX, 0,       2);
        add_row(OP_RESIZE,     99,      65,  1, ST_FULL,  VAL_MIN, VAL_MAX, 0,       2);
        add_row(OP_RESIZE,     99,      127, 1, ST_FULL,  VAL_MIN, VAL_MAX, 0,       2);
        // fill to capacity, then pushes at both ends are refused
        add_row(OP_RESIZE,     -1,      64,  1, ST_OK,    VAL_MIN, -1,      0,       64);
        add_row(OP_PUSH_BACK,  5,       0,   1, ST_FULL,  VAL_MIN, -1,      0,       64);
        add_row(OP_PUSH_FRONT, 5,       0,   1, ST_FULL,  VAL_MIN, -1,      0,       64);
        add_row(OP_READ_INDEX, 0,       63,  1, ST_OK,    VAL_MIN, -1,      -1,      64);
        add_row(OP_READ_INDEX, 0,       64,  1, ST_OOB,   VAL_MIN, -1,      0,       64);
        add_row(OP_POP_FRONT,  0,       0,   0, ST_OK,    0,       0,       0,       0);
        add_row(OP_PUSH_FRONT, 123,     0,   0, ST_OK,    0,       0,       0,       0);
        add_row(OP_RESIZE,     0,       3,   0, ST_OK,    0,       0,       0,       0);
        add_row(OP_POP_BACK,   0,       0,   0, ST_OK,    0,       0,       0,       0);
        add_row(OP_CLEAR,      0,       0,   1, ST_OK,    0,       0,       0,       0);
        add_row(OP_RESIZE,     7,       0,   1, ST_OK,    0,       0,       0,       0);
        // head at zero after clear, so this wraps it to the top slot
        add_row(OP_PUSH_FRONT, 42,      0,   0, ST_OK,    0,       0,       0,       0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            send_request(row.op, row.val, row.pos, row.typed, row.res);
        end

        // Random part in four idling phases: none, sender gaps, receiver stalls, both.
        fill_bias = 80;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (n = 0; n < RAND_PHASE; n++)
            begin
                // swing between growing and draining so both full and empty get hit
                if (n % 32 == 0)
                    fill_bias = $urandom_range(1) ? 80 : 25;

                if ($urandom_range(9) == 0)
                    case ($urandom_range(3))
                        0: val = VAL_MAX;
                        1: val = VAL_MIN;
                        2: val = 0;
                        default: val = -1;
                    endcase
                else
                    val = $urandom;
                pos = 7'($urandom_range(127));

                sel = $urandom_range(99);
                if (sel < 60)
                begin
                    if ($urandom_range(99) < fill_bias)
                        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    else
                        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                else if (sel < 80)
                begin
                    op = OP_READ_INDEX;
                    if (held > 0 && $urandom_range(4) != 0)
                        pos = 7'($urandom_range(held - 1));
                end
                else if (sel < 92)
                begin
                    op = OP_RESIZE;
                    sel = $urandom_range(99);
                    if (sel < 60)
                    begin
                        // near the current length, both directions
                        lo  = (held > 4) ? held - 4 : 0;
                        hi  = (held < DEPTH - 4) ? held + 4 : DEPTH;
                        pos = 7'($urandom_range(hi, lo));
                    end
                    else if (sel < 85)
                        pos = 7'($urandom_range(DEPTH));
                    else
                        pos = 7'($urandom_range(127, DEPTH + 1));
                end
                else if (sel < 94)
                    op = OP_CLEAR;
                else
                    op = OP_QUERY;

                send_request(op, val, pos, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // room for a stray late beat after the last expected one
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("double_ended_queue verification clean");
        else
            $display("double_ended_queue verification failed");
        $finish;
    end

endmodule

>>> double_ended_queue.f
+incdir+src
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
